@@ hdl/twsp_pkg.sv @@
// Shared constants and types for the telemetry word stream parser.
package twsp_pkg;

    localparam int BOX_WORDS  = 32;
    localparam int TIME_WORDS = 4;

    localparam logic [15:0] SYNC_WORD = 16'hf811;
    localparam logic [15:0] HDR_TIME  = 16'hfba8;
    localparam logic [15:0] HDR_CMD0  = 16'h2360;
    localparam logic [15:0] HDR_CMD1  = 16'h2380;
    localparam logic [15:0] HDR_HK0   = 16'h2420;
    localparam logic [15:0] HDR_HK1   = 16'h2440;

    localparam logic [2:0] ST_UNLOCKED   = 3'd0;
    localparam logic [2:0] ST_FRAMENUM   = 3'd1;
    localparam logic [2:0] ST_HEADER     = 3'd2;
    localparam logic [2:0] ST_TIME       = 3'd3;
    localparam logic [2:0] ST_CMD_DATA   = 3'd4;
    localparam logic [2:0] ST_CMD_STATUS = 3'd5;
    localparam logic [2:0] ST_HK_STATUS  = 3'd6;
    localparam logic [2:0] ST_HK_DATA    = 3'd7;

    localparam logic [2:0] CLS_DISCARD  = 3'd0;
    localparam logic [2:0] CLS_SYNC     = 3'd1;
    localparam logic [2:0] CLS_FRAMENUM = 3'd2;
    localparam logic [2:0] CLS_HEADER   = 3'd3;
    localparam logic [2:0] CLS_TIME     = 3'd4;
    localparam logic [2:0] CLS_DATA     = 3'd5;
    localparam logic [2:0] CLS_STATUS   = 3'd6;
    localparam logic [2:0] CLS_ERROR    = 3'd7;

    typedef struct packed {
        logic [2:0]  parser_state;
        logic [4:0]  slot_counter;
        logic        side_register;
        logic [15:0] frames_seen;
        logic [15:0] time_blocks_seen;
        logic [15:0] command_frames_seen;
        logic [15:0] housekeeping_frames_seen;
        logic [1:0]  command_sides_seen;
        logic [1:0]  housekeeping_sides_seen;
    } t_parse_state;

    typedef struct packed {
        logic [2:0]  word_class;
        logic [4:0]  slot_index;
        logic        box_side;
        logic        is_housekeeping;
        logic [15:0] word_value;
        logic        time_block_done;
        logic        command_frame_done;
        logic        housekeeping_frame_done;
        logic [15:0] frame_count;
        logic [15:0] time_block_count;
        logic [15:0] command_frame_count;
        logic [15:0] housekeeping_frame_count;
    } t_word_result;

endpackage

@@ hdl/twsp_decode.sv @@
// Per-word frame decode: next parser state and the tagged result for one word.
module twsp_decode (
    input  twsp_pkg::t_parse_state i_state,
    input  logic [15:0]            i_word,
    output twsp_pkg::t_parse_state o_next,
    output twsp_pkg::t_word_result o_result
);

    logic [5:0] slot_inc;
    logic       time_last;
    logic       box_last;
    logic [1:0] sides;

    assign slot_inc  = {1'b0, i_state.slot_counter} + 6'd1;
    assign time_last = slot_inc >= 6'(twsp_pkg::TIME_WORDS);
    assign box_last  = slot_inc >= 6'(twsp_pkg::BOX_WORDS);

    always_comb begin
        o_next   = i_state;
        o_result = '0;
        sides    = 2'b00;
        o_result.word_value = i_word;
        unique case (i_state.parser_state)
            twsp_pkg::ST_UNLOCKED: begin
                if (i_word == twsp_pkg::SYNC_WORD) begin
                    o_result.word_class = twsp_pkg::CLS_SYNC;
                    o_next.parser_state = twsp_pkg::ST_FRAMENUM;
                end else begin
                    o_result.word_class = twsp_pkg::CLS_DISCARD;
                end
            end
            twsp_pkg::ST_FRAMENUM: begin
                o_result.word_class = twsp_pkg::CLS_FRAMENUM;
                o_next.frames_seen  = i_state.frames_seen + 16'd1;
                o_next.parser_state = twsp_pkg::ST_HEADER;
            end
            twsp_pkg::ST_HEADER: begin
                o_next.slot_counter = '0;
                o_result.word_class = twsp_pkg::CLS_HEADER;
                priority if (i_word == twsp_pkg::SYNC_WORD) begin
                    o_result.word_class = twsp_pkg::CLS_SYNC;
                    o_next.parser_state = twsp_pkg::ST_FRAMENUM;
                end else if (i_word == twsp_pkg::HDR_TIME) begin
                    o_next.parser_state = twsp_pkg::ST_TIME;
                end else if (i_word == twsp_pkg::HDR_CMD0 || i_word == twsp_pkg::HDR_CMD1) begin
                    o_next.side_register = (i_word == twsp_pkg::HDR_CMD1);
                    o_result.box_side    = (i_word == twsp_pkg::HDR_CMD1);
                    o_next.parser_state  = twsp_pkg::ST_CMD_DATA;
                end else if (i_word == twsp_pkg::HDR_HK0 || i_word == twsp_pkg::HDR_HK1) begin
                    o_next.side_register     = (i_word == twsp_pkg::HDR_HK1);
                    o_result.box_side        = (i_word == twsp_pkg::HDR_HK1);
                    o_result.is_housekeeping = 1'b1;
                    o_next.parser_state      = twsp_pkg::ST_HK_STATUS;
                end else begin
                    o_result.word_class = twsp_pkg::CLS_ERROR;
                    o_next.parser_state = twsp_pkg::ST_UNLOCKED;
                end
            end
            twsp_pkg::ST_TIME: begin
                o_result.word_class = twsp_pkg::CLS_TIME;
                o_result.slot_index = i_state.slot_counter;
                if (time_last) begin
                    o_result.time_block_done = 1'b1;
                    o_next.time_blocks_seen  = i_state.time_blocks_seen + 16'd1;
                    o_next.slot_counter      = '0;
                    o_next.parser_state      = twsp_pkg::ST_HEADER;
                end else begin
                    o_next.slot_counter = slot_inc[4:0];
                end
            end
            twsp_pkg::ST_CMD_DATA: begin
                o_result.word_class = twsp_pkg::CLS_DATA;
                o_result.slot_index = i_state.slot_counter;
                o_result.box_side   = i_state.side_register;
                if (box_last) begin
                    o_next.slot_counter = '0;
                    o_next.parser_state = twsp_pkg::ST_CMD_STATUS;
                end else begin
                    o_next.slot_counter = slot_inc[4:0];
                end
            end
            twsp_pkg::ST_CMD_STATUS: begin
                o_result.word_class = twsp_pkg::CLS_STATUS;
                o_result.box_side   = i_state.side_register;
                sides = i_state.command_sides_seen
                      | (i_state.side_register ? 2'b10 : 2'b01);
                if (sides == 2'b11) begin
                    o_next.command_sides_seen  = 2'b00;
                    o_next.command_frames_seen = i_state.command_frames_seen + 16'd1;
                    o_result.command_frame_done = 1'b1;
                end else begin
                    o_next.command_sides_seen = sides;
                end
                o_next.parser_state = twsp_pkg::ST_HEADER;
            end
            twsp_pkg::ST_HK_STATUS: begin
                o_result.word_class      = twsp_pkg::CLS_STATUS;
                o_result.box_side        = i_state.side_register;
                o_result.is_housekeeping = 1'b1;
                o_next.slot_counter      = '0;
                o_next.parser_state      = twsp_pkg::ST_HK_DATA;
            end
            twsp_pkg::ST_HK_DATA: begin
                o_result.word_class      = twsp_pkg::CLS_DATA;
                o_result.slot_index      = i_state.slot_counter;
                o_result.box_side        = i_state.side_register;
                o_result.is_housekeeping = 1'b1;
                if (box_last) begin
                    o_next.slot_counter = '0;
                    sides = i_state.housekeeping_sides_seen
                          | (i_state.side_register ? 2'b10 : 2'b01);
                    if (sides == 2'b11) begin
                        o_next.housekeeping_sides_seen  = 2'b00;
                        o_next.housekeeping_frames_seen =
                            i_state.housekeeping_frames_seen + 16'd1;
                        o_result.housekeeping_frame_done = 1'b1;
                    end else begin
                        o_next.housekeeping_sides_seen = sides;
                    end
                    o_next.parser_state = twsp_pkg::ST_HEADER;
                end else begin
                    o_next.slot_counter = slot_inc[4:0];
                end
            end
            default: begin
                o_next = i_state;
            end
        endcase
        o_result.frame_count              = o_next.frames_seen;
        o_result.time_block_count         = o_next.time_blocks_seen;
        o_result.command_frame_count      = o_next.command_frames_seen;
        o_result.housekeeping_frame_count = o_next.housekeeping_frames_seen;
    end

endmodule

@@ hdl/telemetry_word_stream_parser.sv @@
// Telemetry word stream parser top level: input register, decode, result register.
// An accepted word is held in the input reg, then in the result reg, with decode between.
// Throughput: one word per cycle while the result side keeps taking words.
// Parser state is updated as a word moves from the input reg to the result reg.
// Reset (synchronous, active low): unlocked, slot/side zero, all counters and
// side flags zero, both pipeline stages empty.
module telemetry_word_stream_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_bus_word,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_word_class,
    output logic [4:0]  o_slot_index,
    output logic        o_box_side,
    output logic        o_is_housekeeping,
    output logic [15:0] o_word_value,
    output logic        o_time_block_done,
    output logic        o_command_frame_done,
    output logic        o_housekeeping_frame_done,
    output logic [15:0] o_frame_count,
    output logic [15:0] o_time_block_count,
    output logic [15:0] o_command_frame_count,
    output logic [15:0] o_housekeeping_frame_count
);

    logic                   r_in_valid;
    logic [15:0]            r_in_word;
    logic                   r_out_valid;
    twsp_pkg::t_word_result r_result;
    twsp_pkg::t_parse_state r_state;
    twsp_pkg::t_parse_state n_state;
    twsp_pkg::t_word_result n_result;
    logic                   advance;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    twsp_decode u_decode (
        .i_state  (r_state),
        .i_word   (r_in_word),
        .o_next   (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_word <= i_bus_word;
        end
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid                = r_out_valid;
    assign o_word_class               = r_result.word_class;
    assign o_slot_index               = r_result.slot_index;
    assign o_box_side                 = r_result.box_side;
    assign o_is_housekeeping          = r_result.is_housekeeping;
    assign o_word_value               = r_result.word_value;
    assign o_time_block_done          = r_result.time_block_done;
    assign o_command_frame_done       = r_result.command_frame_done;
    assign o_housekeeping_frame_done  = r_result.housekeeping_frame_done;
    assign o_frame_count              = r_result.frame_count;
    assign o_time_block_count         = r_result.time_block_count;
    assign o_command_frame_count      = r_result.command_frame_count;
    assign o_housekeeping_frame_count = r_result.housekeeping_frame_count;

`ifndef NO_ASSERTIONS
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in_word))
        else $error("input stage lost or changed a stalled word");

    a_time_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_time_block_done |-> o_word_class == twsp_pkg::CLS_TIME)
        else $error("time block done on a non-time word");

    a_cmd_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_command_frame_done |->
            o_word_class == twsp_pkg::CLS_STATUS && !o_is_housekeeping)
        else $error("command frame done on a wrong word");

    a_hk_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_housekeeping_frame_done |->
            o_word_class == twsp_pkg::CLS_DATA && o_is_housekeeping)
        else $error("housekeeping frame done on a wrong word");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> r_out_valid && $stable(r_result))
        else $error("result register changed while stalled");
`endif

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for the telemetry word stream parser: directed rows, random frames.
`timescale 1ns / 1ps

module tb;

    localparam int RST_CYCLES = 12;
    localparam int LONG_HOLD  = 300;
    localparam int RAND_WORDS = 1750;
    localparam int QUIET_FROM = 1400;
    localparam int LIMIT      = 1000000;

    typedef struct packed {
        logic [15:0] word;
        logic        typed;
        logic [2:0]  cls;
    } t_row;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic [15:0] i_bus_word  = '0;
    logic        i_out_ready = 1'b0;

    logic        o_in_ready;
    logic        o_out_valid;
    logic [2:0]  o_word_class;
    logic [4:0]  o_slot_index;
    logic        o_box_side;
    logic        o_is_housekeeping;
    logic [15:0] o_word_value;
    logic        o_time_block_done;
    logic        o_command_frame_done;
    logic        o_housekeeping_frame_done;
    logic [15:0] o_frame_count;
    logic [15:0] o_time_block_count;
    logic [15:0] o_command_frame_count;
    logic [15:0] o_housekeeping_frame_count;

    telemetry_word_stream_parser dut (.*);

    always #1 i_clk = ~i_clk;

    // predicted parser state
    logic [2:0]  prs_state     = twsp_pkg::ST_UNLOCKED;
    logic [4:0]  slot_cnt      = '0;
    logic        side_reg      = 1'b0;
    logic [15:0] frames_n      = '0;
    logic [15:0] time_blocks_n = '0;
    logic [15:0] cmd_frames_n  = '0;
    logic [15:0] hk_frames_n   = '0;
    logic [1:0]  cmd_sides     = '0;
    logic [1:0]  hk_sides      = '0;

    twsp_pkg::t_word_result expected_words[$];
    twsp_pkg::t_word_result exp_w;

    int          n_err     = 0;
    int          n_checked = 0;
    int          n_sent    = 0;
    int unsigned cycles    = 0;
    bit          idle_en   = 1'b0;
    bit          hold_req  = 1'b0;
    bit          hold_done = 1'b0;

    t_row dir_rows [0:17] = '{
        '{16'h0000, 1'b1, twsp_pkg::CLS_DISCARD},
        '{16'hffff, 1'b1, twsp_pkg::CLS_DISCARD},
        '{twsp_pkg::SYNC_WORD, 1'b1, twsp_pkg::CLS_SYNC},
        '{16'h0000, 1'b1, twsp_pkg::CLS_FRAMENUM},
        '{16'h1234, 1'b1, twsp_pkg::CLS_ERROR},
        '{twsp_pkg::SYNC_WORD, 1'b1, twsp_pkg::CLS_SYNC},
        '{16'hffff, 1'b1, twsp_pkg::CLS_FRAMENUM},
        '{twsp_pkg::SYNC_WORD, 1'b1, twsp_pkg::CLS_SYNC},
        '{16'h0001, 1'b1, twsp_pkg::CLS_FRAMENUM},
        '{twsp_pkg::HDR_TIME, 1'b1, twsp_pkg::CLS_HEADER},
        '{twsp_pkg::SYNC_WORD, 1'b1, twsp_pkg::CLS_TIME},
        '{16'h0000, 1'b1, twsp_pkg::CLS_TIME},
        '{16'hffff, 1'b1, twsp_pkg::CLS_TIME},
        '{16'h5555, 1'b1, twsp_pkg::CLS_TIME},
        '{16'hffff, 1'b1, twsp_pkg::CLS_ERROR},
        '{twsp_pkg::SYNC_WORD, 1'b1, twsp_pkg::CLS_SYNC},
        '{16'h8000, 1'b1, twsp_pkg::CLS_FRAMENUM},
        '{16'h0000, 1'b1, twsp_pkg::CLS_ERROR}
    };

    function automatic twsp_pkg::t_word_result parse_word(logic [15:0] w);
        twsp_pkg::t_word_result r;
        r = '0;
        r.word_value = w;
        case (prs_state)
            twsp_pkg::ST_UNLOCKED: begin
                if (w == twsp_pkg::SYNC_WORD) begin
                    r.word_class = twsp_pkg::CLS_SYNC;
                    prs_state = twsp_pkg::ST_FRAMENUM;
                end else begin
                    r.word_class = twsp_pkg::CLS_DISCARD;
                end
            end
            twsp_pkg::ST_FRAMENUM: begin
                r.word_class = twsp_pkg::CLS_FRAMENUM;
                frames_n = frames_n + 16'd1;
                prs_state = twsp_pkg::ST_HEADER;
            end
            twsp_pkg::ST_HEADER: begin
                slot_cnt = '0;
                r.word_class = twsp_pkg::CLS_HEADER;
                if (w == twsp_pkg::SYNC_WORD) begin
                    r.word_class = twsp_pkg::CLS_SYNC;
                    prs_state = twsp_pkg::ST_FRAMENUM;
                end else if (w == twsp_pkg::HDR_TIME) begin
                    prs_state = twsp_pkg::ST_TIME;
                end else if (w == twsp_pkg::HDR_CMD0 || w == twsp_pkg::HDR_CMD1) begin
                    side_reg = (w == twsp_pkg::HDR_CMD1);
                    r.box_side = side_reg;
                    prs_state = twsp_pkg::ST_CMD_DATA;
                end else if (w == twsp_pkg::HDR_HK0 || w == twsp_pkg::HDR_HK1) begin
                    side_reg = (w == twsp_pkg::HDR_HK1);
                    r.box_side = side_reg;
                    r.is_housekeeping = 1'b1;
                    prs_state = twsp_pkg::ST_HK_STATUS;
                end else begin
                    r.word_class = twsp_pkg::CLS_ERROR;
                    prs_state = twsp_pkg::ST_UNLOCKED;
                end
            end
            twsp_pkg::ST_TIME: begin
                r.word_class = twsp_pkg::CLS_TIME;
                r.slot_index = slot_cnt;
                if (int'(slot_cnt) + 1 >= twsp_pkg::TIME_WORDS) begin
                    r.time_block_done = 1'b1;
                    time_blocks_n = time_blocks_n + 16'd1;
                    slot_cnt = '0;
                    prs_state = twsp_pkg::ST_HEADER;
                end else begin
                    slot_cnt = slot_cnt + 5'd1;
                end
            end
            twsp_pkg::ST_CMD_DATA: begin
                r.word_class = twsp_pkg::CLS_DATA;
                r.slot_index = slot_cnt;
                r.box_side = side_reg;
                if (int'(slot_cnt) + 1 >= twsp_pkg::BOX_WORDS) begin
                    slot_cnt = '0;
                    prs_state = twsp_pkg::ST_CMD_STATUS;
                end else begin
                    slot_cnt = slot_cnt + 5'd1;
                end
            end
            twsp_pkg::ST_CMD_STATUS: begin
                r.word_class = twsp_pkg::CLS_STATUS;
                r.box_side = side_reg;
                cmd_sides = cmd_sides | (2'b01 << side_reg);
                if (cmd_sides == 2'b11) begin
                    cmd_sides = '0;
                    cmd_frames_n = cmd_frames_n + 16'd1;
                    r.command_frame_done = 1'b1;
                end
                prs_state = twsp_pkg::ST_HEADER;
            end
            twsp_pkg::ST_HK_STATUS: begin
                r.word_class = twsp_pkg::CLS_STATUS;
                r.box_side = side_reg;
                r.is_housekeeping = 1'b1;
                slot_cnt = '0;
                prs_state = twsp_pkg::ST_HK_DATA;
            end
            default: begin
                r.word_class = twsp_pkg::CLS_DATA;
                r.slot_index = slot_cnt;
                r.box_side = side_reg;
                r.is_housekeeping = 1'b1;
                if (int'(slot_cnt) + 1 >= twsp_pkg::BOX_WORDS) begin
                    slot_cnt = '0;
                    hk_sides = hk_sides | (2'b01 << side_reg);
                    if (hk_sides == 2'b11) begin
                        hk_sides = '0;
                        hk_frames_n = hk_frames_n + 16'd1;
                        r.housekeeping_frame_done = 1'b1;
                    end
                    prs_state = twsp_pkg::ST_HEADER;
                end else begin
                    slot_cnt = slot_cnt + 5'd1;
                end
            end
        endcase
        r.frame_count = frames_n;
        r.time_block_count = time_blocks_n;
        r.command_frame_count = cmd_frames_n;
        r.housekeeping_frame_count = hk_frames_n;
        return r;
    endfunction

    function automatic logic [15:0] rand_word();
        case ($urandom_range(0, 15))
            0: return twsp_pkg::SYNC_WORD;
            1: return twsp_pkg::HDR_TIME;
            2: return $urandom_range(0, 1) ? twsp_pkg::HDR_CMD1 : twsp_pkg::HDR_CMD0;
            3: return $urandom_range(0, 1) ? twsp_pkg::HDR_HK1 : twsp_pkg::HDR_HK0;
            4: return 16'h0000;
            5: return 16'hffff;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // called at a rising edge; returns at the edge where the word is taken
    task automatic send_word(input logic [15:0] w, input logic typed = 1'b0,
                             input logic [2:0] cls = twsp_pkg::CLS_DISCARD);
        int gap;
        twsp_pkg::t_word_result r;
        gap = (idle_en && $urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_bus_word <= w;
        do @(negedge i_clk); while (!o_in_ready);
        @(posedge i_clk);
        r = parse_word(w);
        if (typed) r.word_class = cls;
        expected_words.push_back(r);
        n_sent++;
    endtask

    task automatic send_block(input int kind, input int len);
        int k;
        case (kind)
            0: begin
                send_word(twsp_pkg::HDR_TIME);
                for (k = 0; k < len && k < twsp_pkg::TIME_WORDS; k++) send_word(rand_word());
            end
            1, 2: begin
                send_word(kind == 2 ? twsp_pkg::HDR_CMD1 : twsp_pkg::HDR_CMD0);
                for (k = 0; k < len && k < twsp_pkg::BOX_WORDS + 1; k++)
                    send_word(rand_word());
            end
            3, 4: begin
                send_word(kind == 4 ? twsp_pkg::HDR_HK1 : twsp_pkg::HDR_HK0);
                for (k = 0; k < len && k < twsp_pkg::BOX_WORDS + 1; k++)
                    send_word(rand_word());
            end
            default: begin
                send_word(twsp_pkg::SYNC_WORD);
                send_word(rand_word());
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [15:0] e, input logic [15:0] a);
        if (e !== a) begin
            n_err++;
            $error("%s: expected 0x%0h, got 0x%0h", name, e, a);
        end
    endtask

    always @(negedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_words.size() == 0) begin
                n_err++;
                $error("word out with nothing expected: 0x%0h", o_word_value);
            end else begin
                exp_w = expected_words.pop_front();
                n_checked++;
                check_field("word_class", 16'(exp_w.word_class), 16'(o_word_class));
                check_field("slot_index", 16'(exp_w.slot_index), 16'(o_slot_index));
                check_field("box_side", 16'(exp_w.box_side), 16'(o_box_side));
                check_field("is_housekeeping", 16'(exp_w.is_housekeeping),
                            16'(o_is_housekeeping));
                check_field("word_value", exp_w.word_value, o_word_value);
                check_field("time_block_done", 16'(exp_w.time_block_done),
                            16'(o_time_block_done));
                check_field("command_frame_done", 16'(exp_w.command_frame_done),
                            16'(o_command_frame_done));
                check_field("housekeeping_frame_done", 16'(exp_w.housekeeping_frame_done),
                            16'(o_housekeeping_frame_done));
                check_field("frame_count", exp_w.frame_count, o_frame_count);
                check_field("time_block_count", exp_w.time_block_count, o_time_block_count);
                check_field("command_frame_count", exp_w.command_frame_count,
                            o_command_frame_count);
                check_field("housekeeping_frame_count", exp_w.housekeeping_frame_count,
                            o_housekeeping_frame_count);
            end
        end
    end

    // result side: short random stalls, one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else if (idle_en && $urandom_range(0, 4) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    initial begin
        int k;
        int nblk;
        int pick;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_en = 1'b1;
        foreach (dir_rows[r]) send_word(dir_rows[r].word, dir_rows[r].typed, dir_rows[r].cls);

        while (n_sent < RAND_WORDS) begin
            idle_en = (n_sent < QUIET_FROM) && ($urandom_range(0, 3) != 0);
            if (!hold_done && n_sent > 500) begin
                hold_req = 1'b1;
                hold_done = 1'b1;
            end
            pick = $urandom_range(0, 19);
            if (pick < 16) begin
                send_word(twsp_pkg::SYNC_WORD);
                send_word(16'($urandom_range(0, 65535)));
                nblk = $urandom_range(1, 5);
                for (k = 0; k < nblk; k++) send_block($urandom_range(0, 5), 40);
                if ($urandom_range(0, 3) == 0) send_word(16'($urandom_range(0, 65535)));
            end else if (pick < 18) begin
                nblk = $urandom_range(1, 8);
                for (k = 0; k < nblk; k++) send_word(rand_word());
            end else begin
                send_word(twsp_pkg::SYNC_WORD);
                send_word(rand_word());
                send_block($urandom_range(0, 4), $urandom_range(0, 12));
            end
        end
        idle_en = 1'b0;
        i_in_valid <= 1'b0;

        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("tb: %0d words checked; %0d frames, %0d time blocks", n_checked,
                 frames_n, time_blocks_n);
        $display("tb: %0d command and %0d housekeeping frames, one long output stall",
                 cmd_frames_n, hk_frames_n);
        if (n_err == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
